[hdl/dtbts_pkg.sv]
// Shared types and constants of the depth-tested bilinear texture shader.
// Holds field widths, opcodes, register indexes and the texel quad type.
// Depends on nothing.
package dtbts_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int TEX_SIZE_DEF   = 256;
    localparam int DEPTH_BITS_DEF = 24;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = FRAC_BITS + 2;
    localparam int CH_W       = 8;
    localparam int RGB_W      = 3 * CH_W;
    localparam int ROW_W      = CH_W + FRAC_BITS;
    localparam int XY_W       = 10;
    localparam int Z_W        = 24;
    localparam int SCR_W      = 11;
    localparam int TL_W       = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SHADE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_W   = 3'd0,
        REG_SCREEN_H   = 3'd1,
        REG_TEX_LAST_U = 3'd2,
        REG_TEX_LAST_V = 3'd3
    } t_reg;

    typedef struct packed {
        logic [RGB_W-1:0] t00;
        logic [RGB_W-1:0] t10;
        logic [RGB_W-1:0] t01;
        logic [RGB_W-1:0] t11;
    } t_quad;

    typedef struct packed {
        logic busy;
        logic done;
    } t_filt_stat;

endpackage

[hdl/depth_tested_bilinear_texture_shade.sv]
// Top level of the depth-tested bilinear texture shader.
// Instantiates dtbts_ram twice and dtbts_filter; uses dtbts_pkg.
//
// After reset the block sweeps the depth store to far, one entry per cycle,
// over all MAX_WIDTH*MAX_HEIGHT entries, and takes no beat meanwhile;
// configuration writes are taken at any time. Items are handled one at a time.
// Texel loads, depth resets, unused ops and fragments rejected by position or
// depth flag end in the idle state; a fragment failing the depth test ends
// after the depth read, and a passing one with black color goes to the output.
// A passing textured fragment takes the depth read, four texel reads through
// the single texture port, and nine steps of the shared interpolation
// multiplier (two row blends and one column blend per channel).
// A finished pixel waits in the output register while the next beat is taken.
module depth_tested_bilinear_texture_shade #(
    parameter int MAX_WIDTH  = dtbts_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtbts_pkg::MAX_HEIGHT_DEF,
    parameter int TEX_SIZE   = dtbts_pkg::TEX_SIZE_DEF,
    parameter int DEPTH_BITS = dtbts_pkg::DEPTH_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // texel_u, texel_v, texel_rgb, frag_x, frag_y, frag_z, frag_z_invalid,
    // frag_u, frag_v, frag_uv_invalid, then zero padding.
    input  logic [127:0]                    s_axis_tdata,
    // op.
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_x, out_y, out_color.
    output logic [47:0]                     m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dtbts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dtbts_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dtbts_pkg::*;

    localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_W     = $clog2(PIX_DEPTH);
    localparam int TEX_DEPTH = TEX_SIZE * TEX_SIZE;
    localparam int TA_W      = $clog2(TEX_DEPTH);
    localparam int TI_W      = $clog2(TEX_SIZE);
    localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIX_DEPTH - 1);

    localparam int IN_TU_LO  = 0;
    localparam int IN_TV_LO  = IN_TU_LO + TL_W;
    localparam int IN_RGB_LO = IN_TV_LO + TL_W;
    localparam int IN_X_LO   = IN_RGB_LO + RGB_W;
    localparam int IN_Y_LO   = IN_X_LO + XY_W;
    localparam int IN_Z_LO   = IN_Y_LO + XY_W;
    localparam int IN_ZINV   = IN_Z_LO + Z_W;
    localparam int IN_U_LO   = IN_ZINV + 1;
    localparam int IN_V_LO   = IN_U_LO + COORD_W;
    localparam int IN_UVINV  = IN_V_LO + COORD_W;
    localparam int OUT_Y_LO  = XY_W;
    localparam int OUT_C_LO  = 2 * XY_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DEPTH = 6'b000100,
        S_TEX   = 6'b001000,
        S_FILT  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    typedef struct packed {
        logic [TL_W-1:0]      lo;
        logic [TL_W-1:0]      hi;
        logic [FRAC_BITS-1:0] fr;
    } t_split;

    function automatic t_split split_coord(input logic [COORD_W-1:0] c,
                                           input logic [TL_W-1:0] last);
        logic [FRAC_BITS:0]      cu;
        logic [FRAC_BITS+TL_W:0] s;
        t_split                  r;
        cu = (c[COORD_W-2:0] > {1'b1, {FRAC_BITS{1'b0}}}) ?
             {1'b1, {FRAC_BITS{1'b0}}} : c[FRAC_BITS:0];
        s = cu * last;
        r.lo = s[FRAC_BITS +: TL_W];
        r.fr = s[FRAC_BITS-1:0];
        r.hi = (r.lo != last) ? TL_W'(r.lo + 1'b1) : r.lo;
        return r;
    endfunction

    function automatic logic [TI_W-1:0] clamp_idx(input logic [TL_W-1:0] i);
        if (int'(i) >= TEX_SIZE) begin
            return TI_W'(TEX_SIZE - 1);
        end
        return TI_W'(i);
    endfunction

    function automatic logic [TA_W-1:0] tex_addr(input logic [TI_W-1:0] ui,
                                                 input logic [TI_W-1:0] vi);
        return TA_W'(int'(ui) * TEX_SIZE + int'(vi));
    endfunction

    t_state               r_state, n_state;
    logic [PIX_W-1:0]     r_clr_addr, n_clr_addr;
    logic [2:0]           r_tcnt, n_tcnt;
    logic [XY_W-1:0]      r_x, n_x;
    logic [XY_W-1:0]      r_y, n_y;
    logic [DEPTH_BITS-1:0] r_z, n_z;
    logic [PIX_W-1:0]     r_pix, n_pix;
    logic [COORD_W-1:0]   r_u, n_u;
    logic [COORD_W-1:0]   r_v, n_v;
    logic                 r_uv_inv, n_uv_inv;
    logic [TI_W-1:0]      r_ul, n_ul, r_ur, n_ur, r_vl, n_vl, r_vr, n_vr;
    logic [FRAC_BITS-1:0] r_fu, n_fu, r_fv, n_fv;
    logic                 r_black, n_black;
    t_quad                r_quad, n_quad;
    logic [SCR_W-1:0]     r_scr_w, r_scr_h;
    logic [TL_W-1:0]      r_last_u, r_last_v;
    logic                 r_out_valid, n_out_valid;
    logic [XY_W-1:0]      r_out_x, n_out_x, r_out_y, n_out_y;
    logic [RGB_W-1:0]     r_out_color, n_out_color;

    logic               in_accept;
    t_op                in_op;
    logic [TL_W-1:0]    in_tu, in_tv;
    logic [RGB_W-1:0]   in_rgb;
    logic [XY_W-1:0]    in_x, in_y;
    logic [Z_W-1:0]     in_z;
    logic               in_zinv;
    logic [COORD_W-1:0] in_u, in_v;
    logic               in_uvinv;
    logic               in_on_store, in_on_screen;
    logic [PIX_W-1:0]   in_pix;

    logic                  tex_we;
    logic [TA_W-1:0]       tex_waddr, tex_raddr;
    logic [RGB_W-1:0]      tex_rdata;
    logic                  dep_we;
    logic [PIX_W-1:0]      dep_waddr;
    logic [DEPTH_BITS-1:0] dep_wdata, dep_rdata;

    t_split        sp_u, sp_v;
    logic          filt_start;
    t_filt_stat    filt_stat;
    logic [RGB_W-1:0] filt_color;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_op     = t_op'(s_axis_tuser);
    assign in_tu     = s_axis_tdata[IN_TU_LO +: TL_W];
    assign in_tv     = s_axis_tdata[IN_TV_LO +: TL_W];
    assign in_rgb    = s_axis_tdata[IN_RGB_LO +: RGB_W];
    assign in_x      = s_axis_tdata[IN_X_LO +: XY_W];
    assign in_y      = s_axis_tdata[IN_Y_LO +: XY_W];
    assign in_z      = s_axis_tdata[IN_Z_LO +: Z_W];
    assign in_zinv   = s_axis_tdata[IN_ZINV];
    assign in_u      = s_axis_tdata[IN_U_LO +: COORD_W];
    assign in_v      = s_axis_tdata[IN_V_LO +: COORD_W];
    assign in_uvinv  = s_axis_tdata[IN_UVINV];

    assign in_on_store  = (int'(in_x) < MAX_WIDTH) && (int'(in_y) < MAX_HEIGHT);
    assign in_on_screen = (in_x != '0) && ({1'b0, in_x} < r_scr_w) &&
                          (in_y != '0) && ({1'b0, in_y} < r_scr_h);
    assign in_pix = PIX_W'(int'(in_y) * MAX_WIDTH + int'(in_x));

    assign sp_u = split_coord(r_u, r_last_u);
    assign sp_v = split_coord(r_v, r_last_v);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    // Texture store write on a load beat, reads walk the four corners.
    assign tex_we    = in_accept && (in_op == OP_LOAD) &&
                       (int'(in_tu) < TEX_SIZE) && (int'(in_tv) < TEX_SIZE);
    assign tex_waddr = tex_addr(TI_W'(in_tu), TI_W'(in_tv));

    always_comb begin
        case (r_tcnt)
            3'd0:    tex_raddr = tex_addr(r_ul, r_vl);
            3'd1:    tex_raddr = tex_addr(r_ur, r_vl);
            3'd2:    tex_raddr = tex_addr(r_ul, r_vr);
            default: tex_raddr = tex_addr(r_ur, r_vr);
        endcase
    end

    always_comb begin
        dep_we    = 1'b0;
        dep_waddr = r_pix;
        dep_wdata = {DEPTH_BITS{1'b1}};
        if (r_state == S_CLEAR) begin
            dep_we    = 1'b1;
            dep_waddr = r_clr_addr;
        end else if (r_state == S_DEPTH) begin
            dep_we    = (r_z < dep_rdata);
            dep_wdata = r_z;
        end else if (in_accept && (in_op == OP_CLEAR) && in_on_store) begin
            dep_we    = 1'b1;
            dep_waddr = in_pix;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_tcnt      = r_tcnt;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_pix       = r_pix;
        n_u         = r_u;
        n_v         = r_v;
        n_uv_inv    = r_uv_inv;
        n_ul        = r_ul;
        n_ur        = r_ur;
        n_vl        = r_vl;
        n_vr        = r_vr;
        n_fu        = r_fu;
        n_fv        = r_fv;
        n_black     = r_black;
        n_quad      = r_quad;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_color = r_out_color;
        filt_start  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == PIX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_x      = in_x;
                n_y      = in_y;
                n_z      = DEPTH_BITS'(in_z);
                n_pix    = in_pix;
                n_u      = in_u;
                n_v      = in_v;
                n_uv_inv = in_uvinv;
                if (in_accept && (in_op == OP_SHADE) && in_on_store &&
                        in_on_screen && !in_zinv) begin
                    n_state = S_DEPTH;
                end
            end
            S_DEPTH: begin
                n_ul    = clamp_idx(sp_u.lo);
                n_ur    = clamp_idx(sp_u.hi);
                n_vl    = clamp_idx(sp_v.lo);
                n_vr    = clamp_idx(sp_v.hi);
                n_fu    = sp_u.fr;
                n_fv    = sp_v.fr;
                n_black = r_uv_inv || r_u[COORD_W-1] || r_v[COORD_W-1];
                n_tcnt  = 3'd0;
                if (!(r_z < dep_rdata)) begin
                    n_state = S_IDLE;
                end else if (n_black) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_TEX;
                end
            end
            S_TEX: begin
                n_tcnt = r_tcnt + 3'd1;
                case (r_tcnt)
                    3'd1:    n_quad.t00 = tex_rdata;
                    3'd2:    n_quad.t10 = tex_rdata;
                    3'd3:    n_quad.t01 = tex_rdata;
                    3'd4:    n_quad.t11 = tex_rdata;
                    default: n_quad = r_quad;
                endcase
                if (r_tcnt == 3'd4) begin
                    filt_start = 1'b1;
                    n_state    = S_FILT;
                end
            end
            S_FILT: begin
                if (filt_stat.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_x;
                    n_out_y     = r_y;
                    n_out_color = r_black ? '0 : filt_color;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_tcnt      <= 3'd0;
            r_out_valid <= 1'b0;
            r_scr_w     <= SCR_W'(800);
            r_scr_h     <= SCR_W'(600);
            r_last_u    <= TL_W'(255);
            r_last_v    <= TL_W'(255);
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_tcnt      <= n_tcnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_SCREEN_W:   r_scr_w  <= i_cfg_data[SCR_W-1:0];
                    REG_SCREEN_H:   r_scr_h  <= i_cfg_data[SCR_W-1:0];
                    REG_TEX_LAST_U: r_last_u <= i_cfg_data[TL_W-1:0];
                    REG_TEX_LAST_V: r_last_v <= i_cfg_data[TL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_x         <= n_x;
        r_y         <= n_y;
        r_z         <= n_z;
        r_pix       <= n_pix;
        r_u         <= n_u;
        r_v         <= n_v;
        r_uv_inv    <= n_uv_inv;
        r_ul        <= n_ul;
        r_ur        <= n_ur;
        r_vl        <= n_vl;
        r_vr        <= n_vr;
        r_fu        <= n_fu;
        r_fv        <= n_fv;
        r_black     <= n_black;
        r_quad      <= n_quad;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_color <= n_out_color;
    end

    dtbts_ram #(
        .WIDTH(RGB_W),
        .DEPTH(TEX_DEPTH)
    ) u_tex_ram (
        .i_clk   (i_clk),
        .i_we    (tex_we),
        .i_waddr (tex_waddr),
        .i_wdata (in_rgb),
        .i_raddr (tex_raddr),
        .o_rdata (tex_rdata)
    );

    dtbts_ram #(
        .WIDTH(DEPTH_BITS),
        .DEPTH(PIX_DEPTH)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (dep_waddr),
        .i_wdata (dep_wdata),
        .i_raddr (in_pix),
        .o_rdata (dep_rdata)
    );

    dtbts_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (filt_start),
        .i_quad  (r_quad),
        .i_fu    (r_fu),
        .i_fv    (r_fv),
        .o_stat  (filt_stat),
        .o_color (filt_color)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_color, r_out_y, r_out_x};

    a_filt_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        filt_start |-> !filt_stat.busy)
        else $error("filter started while still busy");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !m_axis_tready) |=>
        (r_state == S_EMIT && r_out_valid))
        else $error("pending pixel overwritten or dropped");

    a_depth_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dep_we |-> (r_state == S_CLEAR || r_state == S_DEPTH ||
                    (in_accept && in_op == OP_CLEAR)))
        else $error("depth store written outside a clear or depth update");

endmodule

[hdl/dtbts_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the texture store and the depth store. No package dependency.
module dtbts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/dtbts_filter.sv]
// Bilinear filter: one shared interpolation multiplier stepped over the three
// color channels, two row blends and one column blend each. Uses dtbts_pkg.
module dtbts_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  dtbts_pkg::t_quad              i_quad,
    input  logic [dtbts_pkg::FRAC_BITS-1:0] i_fu,
    input  logic [dtbts_pkg::FRAC_BITS-1:0] i_fv,
    output dtbts_pkg::t_filt_stat         o_stat,
    output logic [dtbts_pkg::RGB_W-1:0]   o_color
);
    import dtbts_pkg::*;

    localparam int DIFF_W = ROW_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_ROW0 = 4'b0010,
        F_ROW1 = 4'b0100,
        F_MIX  = 4'b1000
    } t_fstate;

    t_fstate            r_state, n_state;
    logic [1:0]         r_chan, n_chan;
    logic [ROW_W-1:0]   r_row0, n_row0;
    logic [ROW_W-1:0]   r_row1, n_row1;
    logic [RGB_W-1:0]   r_color, n_color;
    logic               r_done, n_done;

    logic [CH_W-1:0]          c00, c10, c01, c11;
    logic [ROW_W-1:0]         op_a, op_b;
    logic [FRAC_BITS-1:0]     op_f;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] lerp;

    assign c00 = i_quad.t00[r_chan*CH_W +: CH_W];
    assign c10 = i_quad.t10[r_chan*CH_W +: CH_W];
    assign c01 = i_quad.t01[r_chan*CH_W +: CH_W];
    assign c11 = i_quad.t11[r_chan*CH_W +: CH_W];

    always_comb begin
        case (r_state)
            F_ROW0: begin
                op_a = ROW_W'(c00);
                op_b = ROW_W'(c10);
                op_f = i_fu;
            end
            F_ROW1: begin
                op_a = ROW_W'(c01);
                op_b = ROW_W'(c11);
                op_f = i_fu;
            end
            default: begin
                op_a = r_row0;
                op_b = r_row1;
                op_f = i_fv;
            end
        endcase
    end

    // a*(1-f) + b*f is computed as a*1 + (b-a)*f, which is exact.
    assign diff = $signed({1'b0, op_b}) - $signed({1'b0, op_a});
    assign prod = diff * $signed({1'b0, op_f});
    assign lerp = $signed({2'b00, op_a, {FRAC_BITS{1'b0}}}) + prod;

    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        n_row0  = r_row0;
        n_row1  = r_row1;
        n_color = r_color;
        n_done  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_state = F_ROW0;
                    n_chan  = 2'd0;
                end
            end
            F_ROW0: begin
                n_row0  = lerp[ROW_W-1:0];
                n_state = F_ROW1;
            end
            F_ROW1: begin
                n_row1  = lerp[ROW_W-1:0];
                n_state = F_MIX;
            end
            F_MIX: begin
                n_color[(2 - r_chan)*CH_W +: CH_W] = lerp[2*FRAC_BITS +: CH_W];
                if (r_chan == 2'd2) begin
                    n_state = F_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_chan  = r_chan + 2'd1;
                    n_state = F_ROW0;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_chan  <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
            r_done  <= n_done;
        end
        r_row0  <= n_row0;
        r_row1  <= n_row1;
        r_color <= n_color;
    end

    assign o_stat.busy = (r_state != F_IDLE);
    assign o_stat.done = r_done;
    assign o_color     = r_color;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the depth-tested bilinear texture shader.
// Streams texel loads, depth clears and fragments through several register settings,
// predicts every emitted pixel and checks it; needs dtbts_pkg and the shader RTL.
module tb;
    import dtbts_pkg::*;

    localparam logic [Z_W-1:0]       FAR_DEPTH          = '1;
    localparam logic [63:0]          UNIT_FX            = 64'd1 << FRAC_BITS;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = 3'd4;
    localparam int unsigned          SETTLE_CYCLES      = 40;
    localparam int unsigned          WATCHDOG_LIMIT     = 3_000_000;
    localparam int unsigned          PRINT_LIMIT        = 100;

    typedef struct {
        t_op                       op;
        logic [7:0]                tex_u;
        logic [7:0]                tex_v;
        logic [RGB_W-1:0]          tex_rgb;
        logic [XY_W-1:0]           x;
        logic [XY_W-1:0]           y;
        logic [Z_W-1:0]            z;
        logic                      z_nan;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
        logic                      uv_nan;
    } frag_req_t;

    typedef struct packed {
        logic [RGB_W-1:0] color;
        logic [XY_W-1:0]  y;
        logic [XY_W-1:0]  x;
    } pixel_t;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [127:0]          s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [47:0]           m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    frag_req_t        pending_reqs[$];
    pixel_t           expected_pixels[$];
    logic [RGB_W-1:0] texel_mem[0:65535];
    bit               texel_loaded[0:65535];
    logic [Z_W-1:0]   depth_mem[bit [19:0]];
    logic [SCR_W-1:0] scr_w  = 11'd800;
    logic [SCR_W-1:0] scr_h  = 11'd600;
    logic [TL_W-1:0]  last_u = 8'd255;
    logic [TL_W-1:0]  last_v = 8'd255;
    bit               idle_on = 1'b1;
    int unsigned      items_queued = 0;
    int unsigned      mismatches = 0;
    int unsigned      idle_cycles = 0;
    frag_req_t        drv_req;
    int unsigned      drv_gap = 0;
    int unsigned      mon_stall = 0;

    depth_tested_bilinear_texture_shade dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Splits a nonnegative coordinate into left and right texel index and the right weight.
    function automatic void axis_split(input logic signed [COORD_W-1:0] c,
                                       input logic [TL_W-1:0] last,
                                       output logic [7:0] lo, output logic [7:0] hi,
                                       output logic [FRAC_BITS-1:0] fr);
        logic [16:0] cu;
        logic [24:0] s;
        logic [8:0]  l;
        logic [8:0]  h;
        cu = (c > 18'sd65536) ? 17'h10000 : c[16:0];
        s = 25'(cu) * 25'(last);
        l = s[24:16];
        fr = s[15:0];
        h = (l != {1'b0, last}) ? l + 9'd1 : l;
        lo = (l > 9'd255) ? 8'd255 : l[7:0];
        hi = (h > 9'd255) ? 8'd255 : h[7:0];
    endfunction

    function automatic logic [RGB_W-1:0] bilinear_rgb(input logic signed [COORD_W-1:0] u,
                                                      input logic signed [COORD_W-1:0] v);
        logic [7:0]           ul, ur, vl, vr;
        logic [FRAC_BITS-1:0] fu, fv;
        logic [RGB_W-1:0]     t00, t10, t01, t11, rgb;
        logic [63:0]          c00, c10, c01, c11, row0, row1, val;
        int                   k;
        if (u[COORD_W-1] || v[COORD_W-1]) return '0;
        axis_split(u, last_u, ul, ur, fu);
        axis_split(v, last_v, vl, vr, fv);
        t00 = texel_mem[{ul, vl}];
        t10 = texel_mem[{ur, vl}];
        t01 = texel_mem[{ul, vr}];
        t11 = texel_mem[{ur, vr}];
        rgb = '0;
        for (k = 0; k < 3; k++) begin
            c00 = 64'(t00[8*k +: 8]);
            c10 = 64'(t10[8*k +: 8]);
            c01 = 64'(t01[8*k +: 8]);
            c11 = 64'(t11[8*k +: 8]);
            row0 = c00 * (UNIT_FX - fu) + c10 * fu;
            row1 = c01 * (UNIT_FX - fu) + c11 * fu;
            val = (row0 * (UNIT_FX - fv) + row1 * fv) >> (2 * FRAC_BITS);
            if (val > 64'd255) val = 64'd255;
            rgb[16 - 8*k +: 8] = val[7:0];
        end
        return rgb;
    endfunction

    task automatic predict_pixel(input frag_req_t r);
        bit [19:0]      pix;
        logic [Z_W-1:0] stored;
        pixel_t         exp_pix;
        pix = {r.y, r.x};
        case (r.op)
            OP_LOAD: texel_mem[{r.tex_u, r.tex_v}] = r.tex_rgb;
            OP_CLEAR: depth_mem[pix] = FAR_DEPTH;
            OP_SHADE: begin
                stored = depth_mem.exists(pix) ? depth_mem[pix] : FAR_DEPTH;
                if (r.x != 0 && r.x < scr_w && r.y != 0 && r.y < scr_h && !r.z_nan
                        && r.z < stored) begin
                    depth_mem[pix] = r.z;
                    exp_pix = '{color: r.uv_nan ? '0 : bilinear_rgb(r.u, r.v),
                                y: r.y, x: r.x};
                    expected_pixels = {expected_pixels, exp_pix};
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            drv_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_pixel(drv_req);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    drv_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= drv_req.op;
                    s_axis_tdata <= {6'b0, drv_req.uv_nan, drv_req.v, drv_req.u, drv_req.z_nan,
                                     drv_req.z, drv_req.y, drv_req.x, drv_req.tex_rgb,
                                     drv_req.tex_v, drv_req.tex_u};
                    drv_gap <= pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        pixel_t got;
        pixel_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            mon_stall <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = pixel_t'(m_axis_tdata[43:0]);
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%06h",
                                              got.x, got.y, got.color));
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.x != want.x)
                        report_mismatch($sformatf("x got %0d want %0d", got.x, want.x));
                    if (got.y != want.y)
                        report_mismatch($sformatf("y got %0d want %0d", got.y, want.y));
                    if (got.color != want.color)
                        report_mismatch($sformatf("color at (%0d,%0d) got %06h want %06h",
                                                  want.x, want.y, got.color, want.color));
                end
            end
            if (mon_stall > 0) begin
                mon_stall <= mon_stall - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                mon_stall <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SCREEN_W: scr_w = data;
            REG_SCREEN_H: scr_h = data;
            REG_TEX_LAST_U: last_u = data[TL_W-1:0];
            REG_TEX_LAST_V: last_v = data[TL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic frag_req_t random_req(input t_op op);
        frag_req_t r;
        r.op = op;
        r.tex_u = 8'($urandom);
        r.tex_v = 8'($urandom);
        r.tex_rgb = 24'($urandom);
        r.x = 10'($urandom);
        r.y = 10'($urandom);
        r.z = 24'($urandom);
        r.z_nan = 1'($urandom);
        r.u = 18'($urandom);
        r.v = 18'($urandom);
        r.uv_nan = 1'($urandom);
        return r;
    endfunction

    task automatic queue_item(input frag_req_t r);
        pending_reqs = {pending_reqs, r};
        items_queued++;
        if (r.op == OP_LOAD) texel_loaded[{r.tex_u, r.tex_v}] = 1'b1;
    endtask

    task automatic queue_load(input logic [7:0] u, input logic [7:0] v,
                              input logic [RGB_W-1:0] rgb);
        frag_req_t r;
        r = random_req(OP_LOAD);
        r.tex_u = u;
        r.tex_v = v;
        r.tex_rgb = rgb;
        queue_item(r);
    endtask

    task automatic queue_clear(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y);
        frag_req_t r;
        r = random_req(OP_CLEAR);
        r.x = x;
        r.y = y;
        queue_item(r);
    endtask

    // Texels that a fragment may sample are loaded first, so no unwritten texel is ever read.
    task automatic queue_shade(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
                               input logic [Z_W-1:0] z, input logic z_nan,
                               input logic signed [COORD_W-1:0] u,
                               input logic signed [COORD_W-1:0] v, input logic uv_nan);
        frag_req_t            r;
        logic [7:0]           ul, ur, vl, vr;
        logic [FRAC_BITS-1:0] fu, fv;
        logic [15:0]          addr[4];
        r = random_req(OP_SHADE);
        r.x = x;
        r.y = y;
        r.z = z;
        r.z_nan = z_nan;
        r.u = u;
        r.v = v;
        r.uv_nan = uv_nan;
        if (!uv_nan && !z_nan && !u[COORD_W-1] && !v[COORD_W-1] && x != 0 && x < scr_w
                && y != 0 && y < scr_h) begin
            axis_split(u, last_u, ul, ur, fu);
            axis_split(v, last_v, vl, vr, fv);
            addr = '{{ul, vl}, {ur, vl}, {ul, vr}, {ur, vr}};
            foreach (addr[i]) begin
                if (!texel_loaded[addr[i]]) queue_load(addr[i][15:8], addr[i][7:0], 24'($urandom));
            end
        end
        queue_item(r);
    endtask

    function automatic logic [XY_W-1:0] pick_xy();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 10'($urandom_range(1, 6));
        if (r < 65) return 10'd0;
        if (r < 70) return 10'd1023;
        return 10'($urandom);
    endfunction

    function automatic logic [Z_W-1:0] pick_z();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return FAR_DEPTH;
        if (r < 25) return FAR_DEPTH - 1'b1;
        return 24'($urandom);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 18'($urandom_range(0, 65536));
        if (r < 78) return 18'($urandom_range(65537, 131071));
        if (r < 90) return 18'(32'h40000 - $urandom_range(1, 131072));
        case ($urandom_range(0, 3))
            0: return 18'h00000;
            1: return 18'h10000;
            2: return 18'h1FFFF;
            default: return 18'h20000;
        endcase
    endfunction

    task automatic queue_random();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            queue_load(8'($urandom), 8'($urandom), 24'($urandom));
        end else if (r < 27) begin
            queue_clear(pick_xy(), pick_xy());
        end else if (r < 33) begin
            queue_item(random_req(OP_NONE));
        end else begin
            queue_shade(pick_xy(), pick_xy(), pick_z(), $urandom_range(0, 11) == 0,
                        pick_coord(), pick_coord(), $urandom_range(0, 11) == 0);
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] lu, input logic [CFG_DATA_W-1:0] lv,
                             input int unsigned n, input bit idle);
        int unsigned target;
        drain();
        cfg_write(REG_SCREEN_W, w);
        cfg_write(REG_SCREEN_H, h);
        cfg_write(REG_TEX_LAST_U, lu);
        cfg_write(REG_TEX_LAST_V, lv);
        idle_on = idle;
        target = items_queued + n;
        while (items_queued < target) queue_random();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_load(8'd0, 8'd0, 24'hFFFFFF);
        queue_load(8'd255, 8'd255, 24'h000000);
        queue_load(8'd0, 8'd255, 24'h123456);
        queue_load(8'd255, 8'd0, 24'hA5C3F0);
        queue_shade(10'd1, 10'd1, 24'd0, 1'b0, 18'h00000, 18'h00000, 1'b0);
        queue_shade(10'd1, 10'd1, 24'd0, 1'b0, 18'h00000, 18'h00000, 1'b0);
        queue_clear(10'd1, 10'd1);
        queue_shade(10'd1, 10'd1, 24'd0, 1'b0, 18'h00000, 18'h10000, 1'b0);
        queue_shade(10'd799, 10'd599, FAR_DEPTH - 1'b1, 1'b0, 18'h10000, 18'h10000, 1'b0);
        queue_shade(10'd2, 10'd2, FAR_DEPTH, 1'b0, 18'h00000, 18'h00000, 1'b0);
        queue_shade(10'd800, 10'd5, 24'd9, 1'b0, 18'h00000, 18'h00000, 1'b0);
        queue_shade(10'd5, 10'd600, 24'd9, 1'b0, 18'h00000, 18'h00000, 1'b0);
        queue_shade(10'd0, 10'd5, 24'd9, 1'b0, 18'h00000, 18'h00000, 1'b0);
        queue_shade(10'd5, 10'd0, 24'd9, 1'b0, 18'h00000, 18'h00000, 1'b0);
        queue_shade(10'd1023, 10'd1023, 24'd9, 1'b0, 18'h00000, 18'h00000, 1'b0);
        queue_shade(10'd3, 10'd3, 24'd5, 1'b1, 18'h00000, 18'h00000, 1'b0);
        queue_shade(10'd4, 10'd4, 24'd100, 1'b0, 18'h20000, 18'h1FFFF, 1'b0);
        queue_shade(10'd5, 10'd5, 24'd100, 1'b0, 18'h1FFFF, 18'h1FFFF, 1'b1);
        queue_shade(10'd6, 10'd6, 24'd7, 1'b0, 18'h1FFFF, 18'h08000, 1'b0);
        queue_shade(10'd7, 10'd7, 24'd1, 1'b0, 18'h08000, 18'h04000, 1'b0);
        queue_item(random_req(OP_NONE));
        queue_clear(10'd1023, 10'd1023);
        queue_clear(10'd0, 10'd0);

        run_phase(11'd1024, 11'd1024, 11'd255, 11'd255, 330, 1'b1);
        run_phase(11'd2047, 11'd2047, 11'h700, 11'h7FF, 280, 1'b0);
        drain();
        cfg_write(REG_FIRST_UNMAPPED | 3'($urandom_range(0, 3)), 11'($urandom));
        run_phase(11'd8, 11'd8, 11'd1, 11'd3, 300, 1'b1);
        run_phase(11'd0, 11'd600, 11'd7, 11'd255, 60, 1'b1);
        run_phase(11'd1024, 11'd0, 11'd255, 11'd7, 60, 1'b0);
        run_phase(11'd1, 11'd1, 11'd3, 11'd3, 50, 1'b1);
        run_phase(11'd2, 11'd2, 11'd200, 11'd17, 120, 1'b1);
        run_phase(11'd16, 11'd12, 11'd31, 11'd17, 300, 1'b1);
        run_phase(11'd800, 11'd600, 11'd255, 11'd255, 300, 1'b0);
        drain();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

[files.f]
hdl/dtbts_pkg.sv
hdl/dtbts_ram.sv
hdl/dtbts_filter.sv
hdl/depth_tested_bilinear_texture_shade.sv
tb/tb.sv
